### src/sfv_pkg.sv
// ----------------------------------------------------------------------------
// sfv_pkg: shared types and constants for the 8.3 short name formatter
// Character codes, the forbidden-character check and the queue status word.
// ----------------------------------------------------------------------------
package sfv_pkg;

    localparam logic [7:0] C_SPACE    = 8'h20;
    localparam logic [7:0] C_QUOTE    = 8'h22;
    localparam logic [7:0] C_STAR     = 8'h2A;
    localparam logic [7:0] C_PLUS     = 8'h2B;
    localparam logic [7:0] C_COMMA    = 8'h2C;
    localparam logic [7:0] C_DOT      = 8'h2E;
    localparam logic [7:0] C_SLASH    = 8'h2F;
    localparam logic [7:0] C_COLON    = 8'h3A;
    localparam logic [7:0] C_GREATER  = 8'h3E;
    localparam logic [7:0] C_QUESTION = 8'h3F;
    localparam logic [7:0] C_LBRACKET = 8'h5B;
    localparam logic [7:0] C_RBRACKET = 8'h5D;
    localparam logic [7:0] C_PIPE     = 8'h7C;
    localparam logic [7:0] C_DEL      = 8'h7F;
    localparam logic [7:0] C_LOWER_A  = 8'h61;
    localparam logic [7:0] C_LOWER_Z  = 8'h7A;
    localparam logic [7:0] C_CASE_OFS = 8'h20;

    // status of the name queue as seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // true for bytes that may not appear in a short name; * + and ? pass in search mode
    function automatic logic byte_forbidden(input logic [7:0] c, input logic search);
        logic bad;
        bad = 1'b0;
        if (c <= C_SPACE || c >= C_DEL) bad = 1'b1;
        if (c == C_QUOTE || c == C_COMMA || c == C_SLASH || c == C_PIPE) bad = 1'b1;
        if (c >= C_COLON && c <= C_GREATER) bad = 1'b1;
        if (c >= C_LBRACKET && c <= C_RBRACKET) bad = 1'b1;
        if ((c == C_STAR || c == C_PLUS || c == C_QUESTION) && !search) bad = 1'b1;
        return bad;
    endfunction

    // lower-case letters map to upper case
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= C_LOWER_A && c <= C_LOWER_Z) u = c - C_CASE_OFS;
        return u;
    endfunction

endpackage

### src/sfv_ifaces.sv
// ----------------------------------------------------------------------------
// sfv_ifaces: channel interfaces of the short name formatter
// Character input, formatted result output and the mode write channel.
// ----------------------------------------------------------------------------
interface sfv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       name_end;

    modport source (output valid, output name_char, output name_end, input ready);
    modport sink   (input valid, input name_char, input name_end, output ready);
endinterface

interface sfv_res_if;
    logic       valid;
    logic       ready;
    logic       name_ok;
    logic [3:0] slot;
    logic [7:0] out_byte;
    logic       final_item;

    modport source (output valid, output name_ok, output slot, output out_byte,
                    output final_item, input ready);
    modport sink   (input valid, input name_ok, input slot, input out_byte,
                    input final_item, output ready);
endinterface

interface sfv_cfg_if;
    logic valid;
    logic ready;
    logic search_mode;

    modport source (output valid, output search_mode, input ready);
    modport sink   (input valid, input search_mode, output ready);
endinterface

### src/sfv_front.sv
// ----------------------------------------------------------------------------
// sfv_front: character checker and name builder
// Classifies one character per cycle unless the name queue is full, builds the
// padded name and pushes the finished name with its valid flag into the name queue.
// ----------------------------------------------------------------------------
module sfv_front #(
    parameter int TOTAL_CHARS = 11,
    parameter int BASE_CHARS  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sfv_char_if.sink               i_char,
    sfv_cfg_if.sink                i_cfg,
    input  sfv_pkg::t_q_status     i_q_status,
    output logic                   o_push,
    output logic [8*TOTAL_CHARS:0] o_push_data
);
    import sfv_pkg::*;

    localparam int MAX_SLOT = (TOTAL_CHARS > BASE_CHARS) ? TOTAL_CHARS : BASE_CHARS;
    localparam int SLOT_W   = $clog2(MAX_SLOT + 1);

    logic [7:0]        r_buf [TOTAL_CHARS];
    logic [7:0]        n_buf [TOTAL_CHARS];
    logic [SLOT_W-1:0] r_ws, n_ws;
    logic [3:0]        r_ci;
    logic              r_dot, n_dot;
    logic              r_bad, n_bad;
    logic              r_search;
    logic              w_take;
    logic              w_wr;
    logic [7:0]        w_upper;

    assign i_char.ready = !i_q_status.full;
    assign i_cfg.ready  = 1'b1;
    assign w_take       = i_char.valid && i_char.ready;
    assign w_upper      = to_upper(i_char.name_char);

    // classify the incoming character
    always_comb begin
        n_bad = r_bad;
        n_dot = r_dot;
        n_ws  = r_ws;
        w_wr  = 1'b0;
        if (!r_bad) begin
            if (byte_forbidden(i_char.name_char, r_search)) begin
                n_bad = 1'b1;
            end else if (i_char.name_char == C_DOT) begin
                if (r_dot || r_ci == 4'd0) begin
                    n_bad = 1'b1;
                end else begin
                    n_dot = 1'b1;
                    n_ws  = SLOT_W'(BASE_CHARS);
                end
            end else if (!r_dot && r_ci >= 4'(BASE_CHARS)) begin
                n_bad = 1'b1;
            end else if (r_ws >= SLOT_W'(TOTAL_CHARS)) begin
                n_bad = 1'b1;
            end else begin
                w_wr = 1'b1;
                n_ws = r_ws + SLOT_W'(1);
            end
        end
    end

    // buffer with this character written in
    always_comb begin
        for (int k = 0; k < TOTAL_CHARS; k++) begin
            n_buf[k] = (w_wr && r_ws == SLOT_W'(k)) ? w_upper : r_buf[k];
        end
    end

    // finished name goes to the queue on the last character
    assign o_push = w_take && i_char.name_end;
    always_comb begin
        o_push_data[8*TOTAL_CHARS] = !n_bad;
        for (int k = 0; k < TOTAL_CHARS; k++) begin
            o_push_data[8*k +: 8] = n_buf[k];
        end
    end

    // name state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws  <= '0;
            r_ci  <= '0;
            r_dot <= 1'b0;
            r_bad <= 1'b0;
            for (int k = 0; k < TOTAL_CHARS; k++) r_buf[k] <= C_SPACE;
        end else if (w_take) begin
            if (i_char.name_end) begin
                r_ws  <= '0;
                r_ci  <= '0;
                r_dot <= 1'b0;
                r_bad <= 1'b0;
                for (int k = 0; k < TOTAL_CHARS; k++) r_buf[k] <= C_SPACE;
            end else begin
                r_ws  <= n_ws;
                r_dot <= n_dot;
                r_bad <= n_bad;
                if (r_ci != 4'hF) r_ci <= r_ci + 4'd1;
                for (int k = 0; k < TOTAL_CHARS; k++) r_buf[k] <= n_buf[k];
            end
        end
    end

    // search mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_search <= i_cfg.search_mode;
        end
    end

endmodule

### src/sfv_queue.sv
// ----------------------------------------------------------------------------
// sfv_queue: two-entry name queue
// Holds finished names between the checker and the output serializer.
// ----------------------------------------------------------------------------
module sfv_queue #(
    parameter int WIDTH = 89
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_push_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_pop_data,
    output sfv_pkg::t_q_status o_status
);
    import sfv_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);
    assign o_pop_data     = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_push_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### src/sfv_back.sv
// ----------------------------------------------------------------------------
// sfv_back: result serializer
// Takes one name from the queue and sends it out as formatted words, or
// a single error word for an invalid name.
// ----------------------------------------------------------------------------
module sfv_back #(
    parameter int TOTAL_CHARS = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sfv_pkg::t_q_status     i_q_status,
    input  logic [8*TOTAL_CHARS:0] i_pop_data,
    output logic                   o_pop,
    sfv_res_if.source              o_res
);
    import sfv_pkg::*;

    localparam int IDX_W = $clog2(TOTAL_CHARS);

    logic                     r_busy;
    logic                     r_ok;
    logic [8*TOTAL_CHARS-1:0] r_buf;
    logic [IDX_W-1:0]         r_cnt;
    logic                     w_last;
    logic                     w_done;
    logic                     w_load;

    // output word from the held name
    assign w_last           = !r_ok || (r_cnt == IDX_W'(TOTAL_CHARS - 1));
    assign o_res.valid      = r_busy;
    assign o_res.name_ok    = r_ok;
    assign o_res.slot       = r_ok ? 4'(r_cnt) : 4'd0;
    assign o_res.out_byte   = r_ok ? r_buf[8*r_cnt +: 8] : 8'h00;
    assign o_res.final_item = w_last;

    assign w_done = r_busy && o_res.ready && w_last;
    assign w_load = (!r_busy || w_done) && !i_q_status.empty;
    assign o_pop  = w_load;

    // serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && o_res.ready) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // held name
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ok  <= i_pop_data[8*TOTAL_CHARS];
            r_buf <= i_pop_data[8*TOTAL_CHARS-1:0];
        end
    end

endmodule

### src/short_filename_validate_format.sv
// ----------------------------------------------------------------------------
// short_filename_validate_format: 8.3 short name checker and formatter
// Checks a file name character by character and emits the padded name.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle while the name queue has room. On the last
// character the name is queued (two names deep) and the output side sends it
// as TOTAL_CHARS words, one per cycle while o_res.ready is high, slot 0 first,
// or as a single error word when the name is invalid. Input stalls only when
// both queue entries are full. The search mode register is written through
// i_cfg and applies to later characters.
module short_filename_validate_format #(
    parameter int TOTAL_CHARS = 11,
    parameter int BASE_CHARS  = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfv_char_if.sink  i_char,
    sfv_cfg_if.sink   i_cfg,
    sfv_res_if.source o_res
);
    import sfv_pkg::*;

    localparam int Q_W = 8 * TOTAL_CHARS + 1;

    t_q_status      w_qs;
    logic           w_push;
    logic           w_pop;
    logic [Q_W-1:0] w_push_data;
    logic [Q_W-1:0] w_pop_data;

    // checker side
    sfv_front #(
        .TOTAL_CHARS (TOTAL_CHARS),
        .BASE_CHARS  (BASE_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .i_cfg       (i_cfg),
        .i_q_status  (w_qs),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // name queue
    sfv_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_status    (w_qs)
    );

    // output side
    sfv_back #(
        .TOTAL_CHARS (TOTAL_CHARS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_qs),
        .i_pop_data (w_pop_data),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

    // no push into a full queue, no pop from an empty one
    a_q_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qs.full) && !(w_pop && w_qs.empty))
        else $error("name queue overflow or underflow");

    // an error word is a single final word with zero payload
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.name_ok) |->
        (o_res.final_item && o_res.out_byte == 8'h00 && o_res.slot == 4'd0))
        else $error("malformed error word");

    // slot stays inside the formatted name
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.slot < 4'(TOTAL_CHARS)))
        else $error("slot out of range");

    // output goes idle after the last word when nothing is queued
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.final_item && w_qs.empty) |=> !o_res.valid)
        else $error("output valid without a queued name");

endmodule
